/* design/sha_pkg.sv */
// Shared types, constants and schedule functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadMark    = 8'h80;

  typedef logic [31:0] word_t;

  // Round constants.
  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sm0(input word_t x);
    sm0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sm1(input word_t x);
    sm1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* design/sha_round.sv */
// One SHA-256 round on the working variables, registered, with chain init and fold.
`timescale 1ns / 1ps
module sha_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  logic              start_i,
  input  logic              step_i,
  input  logic              fold_i,
  input  logic [5:0]        round_i,
  input  sha_pkg::word_t    w_i,
  output sha_pkg::word_t    chain_o [8]
);
  import sha_pkg::*;

  word_t st_q [8];
  word_t st_d [8];
  word_t chain_q [8];
  word_t t1, t2;

  // Round datapath.
  always_comb begin
    t1 = st_q[7] + (rotr(st_q[4], 6) ^ rotr(st_q[4], 11) ^ rotr(st_q[4], 25))
       + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6])) + RoundConst[round_i] + w_i;
    t2 = (rotr(st_q[0], 2) ^ rotr(st_q[0], 13) ^ rotr(st_q[0], 22))
       + ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
    st_d[0] = t1 + t2;
    st_d[1] = st_q[0];
    st_d[2] = st_q[1];
    st_d[3] = st_q[2];
    st_d[4] = st_q[3] + t1;
    st_d[5] = st_q[4];
    st_d[6] = st_q[5];
    st_d[7] = st_q[6];
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st_q <= chain_q;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  // Chain value: loaded with the initial values, folded after each block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitChain;
    end else if (init_i) begin
      chain_q <= InitChain;
    end else if (fold_i) begin
      for (int j = 0; j < 8; j++) begin
        chain_q[j] <= chain_q[j] + st_q[j];
      end
    end
  end

  assign chain_o = chain_q;

endmodule

/* design/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: block memory, schedule memory and sequencer.
//
// Usage: the input channel carries one beat per message byte (byte_present_i)
// with end_of_message_i on the last beat; a beat with only end_of_message_i
// closes the message with no byte. Input is taken only while the sequencer is
// idle; each byte is written to the block memory as it is taken. A full block
// of 64 bytes is compressed by a sequencer that copies it into the 16-word
// schedule memory (a read and a write step per word), then runs the 64 rounds:
// rounds 0 to 15 take a read and a round step, rounds 16 to 63 four reads
// and a round step, and a fold step ends the block; no beat is accepted
// meanwhile. A closing beat pads one byte per cycle up to the block
// end and compresses one block, or two when the length does not fit. The
// first digest beat is valid the cycle after the last fold; the four beats
// leave word 0 first, one per cycle while ready_i is high, with last_word_o
// on word 3. A stalled receiver holds the current digest beat; no input is
// taken until all four are out, then the next message starts from the
// initial chain value. Reset clears the control state and restores the chain
// to its initial value; the memories keep their contents and need no clearing.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPad   = 4'd1;
  localparam logic [3:0] StLoadA = 4'd2;
  localparam logic [3:0] StLoadB = 4'd3;
  localparam logic [3:0] StRdA   = 4'd4;
  localparam logic [3:0] StRdB   = 4'd5;
  localparam logic [3:0] StRnd   = 4'd6;
  localparam logic [3:0] StFold  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [6:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [1:0]  sub_q, sub_d;
  logic        closing_q, closing_d;
  logic        final_q, final_d;
  logic        spill_q, spill_d;
  logic [1:0]  oidx_q, oidx_d;

  // Block memory: four byte lanes so that one big-endian word reads at once.
  logic [7:0]  bmem [4][16];
  logic        bwe;
  logic [5:0]  bwaddr;
  logic [7:0]  bwdata;
  logic [3:0]  braddr;
  logic [31:0] brdata_q;

  // Schedule memory.
  word_t       wmem [16];
  logic        wwe;
  logic [3:0]  wwaddr, wraddr;
  word_t       wwdata, wrdata_q;

  word_t       w15_q, w16_q, wsum_q, wr;
  word_t       chain [8];
  logic        rd_init, rd_start, rd_step, rd_fold;
  logic        in_acc, out_acc;

  always_ff @(posedge clk_i) begin
    if (bwe) begin
      bmem[bwaddr[1:0]][bwaddr[5:2]] <= bwdata;
    end
    brdata_q <= {bmem[0][braddr], bmem[1][braddr], bmem[2][braddr], bmem[3][braddr]};
  end

  always_ff @(posedge clk_i) begin
    if (wwe) begin
      wmem[wwaddr] <= wwdata;
    end
    wrdata_q <= wmem[wraddr];
  end

  sha_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (rd_init),
    .start_i (rd_start),
    .step_i  (rd_step),
    .fold_i  (rd_fold),
    .round_i (rnd_q[5:0]),
    .w_i     (wr),
    .chain_o (chain)
  );

  assign in_acc  = valid_i && ready_o;
  assign out_acc = valid_o && ready_i;
  assign ready_o = (state_q == StIdle);
  assign valid_o = (state_q == StOut);

  // Schedule word of the current round; the last operand comes straight from the read port.
  assign wr = (rnd_q < 7'd16) ? wrdata_q : (wsum_q + sm1(wrdata_q));

  // Operand registers filled from the schedule memory read port.
  always_ff @(posedge clk_i) begin
    if (state_q == StRdB) begin
      case (sub_q)
        2'd0:    w16_q  <= wrdata_q;
        2'd1:    w15_q  <= wrdata_q;
        default: wsum_q <= w16_q + sm0(w15_q) + wrdata_q;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; fill_d = fill_q; bits_d = bits_q; rnd_d = rnd_q;
    sub_d = sub_q; closing_d = closing_q; final_d = final_q; spill_d = spill_q;
    oidx_d = oidx_q;
    bwe = 1'b0; bwaddr = fill_q[5:0]; bwdata = data_byte_i;
    braddr = rnd_q[3:0];
    wwe = 1'b0; wwaddr = rnd_q[3:0]; wwdata = wr; wraddr = rnd_q[3:0];
    rd_init = 1'b0; rd_start = 1'b0; rd_step = 1'b0; rd_fold = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          closing_d = end_of_message_i;
          if (byte_present_i) begin
            bwe = 1'b1;
            fill_d = fill_q + 7'd1;
            bits_d = bits_q + 64'd8;
            if (fill_q == 7'd63) begin
              fill_d = 7'd0; rnd_d = 7'd0; state_d = StLoadA;
            end else if (end_of_message_i) begin
              state_d = StPad;
            end
          end else if (end_of_message_i) begin
            state_d = StPad;
          end
        end
      end
      // Pad byte per cycle: mark, zeros, then length bytes. A mark at or past the
      // length slot ends its block with zeros, before a separate length block.
      StPad: begin
        bwe = 1'b1;
        fill_d = fill_q + 7'd1;
        if (!final_q) begin
          bwdata = PadMark; final_d = 1'b1;
          spill_d = (fill_q >= 7'(LenPos));
        end else if (fill_q < 7'(LenPos) || spill_q) begin
          bwdata = 8'd0;
        end else begin
          bwdata = bits_q[{~fill_q[2:0], 3'b111} -: 8];
        end
        if (fill_q == 7'd63) begin
          fill_d = 7'd0; rnd_d = 7'd0; state_d = StLoadA;
          spill_d = 1'b0;
          if (final_q && !spill_q) begin
            closing_d = 1'b0;
          end
        end
      end
      // Copy the block into the schedule memory, one word per read and write state.
      StLoadA: begin
        braddr = rnd_q[3:0];
        state_d = StLoadB;
      end
      StLoadB: begin
        wwe = 1'b1; wwaddr = rnd_q[3:0]; wwdata = brdata_q;
        if (rnd_q == 7'd15) begin
          rnd_d = 7'd0; rd_start = 1'b1; state_d = StRdA;
        end else begin
          rnd_d = rnd_q + 7'd1; state_d = StLoadA;
        end
      end
      StRdA: begin
        wraddr = rnd_q[3:0];
        sub_d = 2'd0;
        state_d = (rnd_q < 7'd16) ? StRnd : StRdB;
      end
      StRdB: begin
        case (sub_q)
          2'd0:    wraddr = rnd_q[3:0] - 4'd15;
          2'd1:    wraddr = rnd_q[3:0] - 4'd7;
          default: wraddr = rnd_q[3:0] - 4'd2;
        endcase
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd2) begin
          state_d = StRnd;
        end
      end
      StRnd: begin
        rd_step = 1'b1;
        wwe = 1'b1; wwaddr = rnd_q[3:0]; wwdata = wr;
        sub_d = 2'd0;
        if (rnd_q == 7'd63) begin
          state_d = StFold;
        end else begin
          rnd_d = rnd_q + 7'd1;
          state_d = StRdA;
        end
      end
      // After the fold: more padding, the digest, or back to taking bytes.
      StFold: begin
        rd_fold = 1'b1;
        rnd_d = 7'd0;
        if (closing_q) begin
          state_d = StPad;
        end else if (final_q) begin
          state_d = StOut; oidx_d = 2'd0;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            state_d = StIdle; rd_init = 1'b1; fill_d = 7'd0; bits_d = '0;
            final_d = 1'b0; closing_d = 1'b0; spill_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; fill_q <= '0; bits_q <= '0; rnd_q <= '0; sub_q <= '0;
      closing_q <= 1'b0; final_q <= 1'b0; spill_q <= 1'b0; oidx_q <= '0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; bits_q <= bits_d; rnd_q <= rnd_d;
      sub_q <= sub_d; closing_q <= closing_d; final_q <= final_d; spill_q <= spill_d;
      oidx_q <= oidx_d;
    end
  end

  assign digest_word_o = {chain[{oidx_q, 1'b0}], chain[{oidx_q, 1'b1}]};
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 2'd3);

  // Checks on the sequencer.
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !ready_o) else $error("input taken while busy");
  a_fill_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 7'd63) else $error("fill count out of range");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && last_word_o |=> ready_o) else $error("no return to idle");
  a_rnd_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRnd |-> rnd_q <= 7'd63) else $error("round index out of range");

endmodule

/* bench/sha256_stream_hasher_test.sv */
// Self-checking testbench for the SHA-256 stream hasher, with its own digest predictor.
`timescale 1ns / 1ps
module sha256_stream_hasher_test;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        valid_o;
  logic        ready_i;
  logic [63:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_beat_t;

  digest_beat_t digest_queue[$];
  word_t        hash_chain[8];
  logic [7:0]   hash_block[64];
  int unsigned  hash_fill;
  logic [63:0]  hash_bits;
  int unsigned  error_count;
  int unsigned  cycle_count;

  sha256_stream_hasher DUT (.*);

  // Clock generator.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sha256_stream_hasher_test NOT OK");
      $finish;
    end
  end

  function automatic word_t rot_right(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  // Compresses the gathered block into the running chain value.
  task automatic compress_hash_block();
    word_t w[64];
    word_t s[8];
    word_t t1;
    word_t t2;
    for (int j = 0; j < 16; j++) begin
      w[j] = {hash_block[4*j], hash_block[4*j+1], hash_block[4*j+2], hash_block[4*j+3]};
    end
    for (int j = 16; j < 64; j++) begin
      w[j] = w[j-16] + w[j-7]
           + (rot_right(w[j-15], 7) ^ rot_right(w[j-15], 18) ^ (w[j-15] >> 3))
           + (rot_right(w[j-2], 17) ^ rot_right(w[j-2], 19) ^ (w[j-2] >> 10));
    end
    s = hash_chain;
    for (int r = 0; r < 64; r++) begin
      t1 = s[7] + (rot_right(s[4], 6) ^ rot_right(s[4], 11) ^ rot_right(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundConst[r] + w[r];
      t2 = (rot_right(s[0], 2) ^ rot_right(s[0], 13) ^ rot_right(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6];
      s[6] = s[5];
      s[5] = s[4];
      s[4] = s[3] + t1;
      s[3] = s[2];
      s[2] = s[1];
      s[1] = s[0];
      s[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_chain[j] = hash_chain[j] + s[j];
  endtask

  task automatic restart_hash();
    hash_chain = InitChain;
    hash_fill  = 0;
    hash_bits  = '0;
  endtask

  // Advances the predictor by one beat and queues any digest words.
  task automatic predict_digest(logic [7:0] data, logic present, logic closing);
    digest_beat_t beat;
    if (present) begin
      hash_block[hash_fill] = data;
      hash_fill++;
      hash_bits = hash_bits + 64'd8;
      if (hash_fill == BlockBytes) begin
        compress_hash_block();
        hash_fill = 0;
      end
    end
    if (closing) begin
      hash_block[hash_fill] = PadMark;
      hash_fill++;
      if (hash_fill > LenPos) begin
        while (hash_fill < BlockBytes) begin
          hash_block[hash_fill] = 8'h00;
          hash_fill++;
        end
        compress_hash_block();
        hash_fill = 0;
      end
      while (hash_fill < LenPos) begin
        hash_block[hash_fill] = 8'h00;
        hash_fill++;
      end
      for (int j = 0; j < 8; j++) hash_block[LenPos+j] = hash_bits[63-8*j -: 8];
      compress_hash_block();
      for (int j = 0; j < 4; j++) begin
        beat.word  = {hash_chain[2*j], hash_chain[2*j+1]};
        beat.index = j[1:0];
        beat.last  = (j == 3);
        digest_queue = {digest_queue, beat};
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, seen, want);
    error_count++;
  endtask

  // Sends one beat, after a random gap, and waits for its acceptance.
  // Valid stays high after acceptance and drops only when a gap follows.
  task automatic send_beat(logic [7:0] data, logic present, logic closing);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i          <= 1'b1;
    data_byte_i      <= data;
    byte_present_i   <= present;
    end_of_message_i <= closing;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    predict_digest(data, present, closing);
  endtask

  task automatic send_message(int unsigned length, logic empty_close);
    for (int unsigned k = 0; k < length; k++) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1, (k == length - 1) && !empty_close);
    end
    if (empty_close || length == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Drops valid and waits until every expected digest beat has come.
  task automatic wait_for_digests();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (digest_queue.size() != 0);
  endtask

  // Receiver stalls: random ready with occasional long holds.
  initial begin
    ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 19) == 0) begin
        ready_i <= 1'b0;
        repeat ($urandom_range(10, 100)) @(posedge clk_i);
      end
      ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Checks each accepted digest beat against the oldest expectation.
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected digest beat", digest_word_o, 64'd0);
      end else begin
        want = digest_queue.pop_front();
        if (digest_word_o !== want.word) report_mismatch("digest_word", digest_word_o, want.word);
        if (word_index_o !== want.index) begin
          report_mismatch("word_index", 64'(word_index_o), 64'(want.index));
        end
        if (last_word_o !== want.last) begin
          report_mismatch("last_word", 64'(last_word_o), 64'(want.last));
        end
      end
    end
  end

  // Empty message, flagless beats, single zero and all-ones bytes, and a byte closed by a flag-only beat.
  task automatic test_short_messages();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'hab, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  // Lengths around the padding boundary: one and two final blocks.
  task automatic test_pad_boundaries();
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(63, 1'b0);
    send_message(64, 1'b1);
  endtask

  // Sender holds off until all digests are out.
  task automatic test_drained_sender();
    send_message(3, 1'b0);
    wait_for_digests();
    send_message(1, 1'b1);
  endtask

  // Random messages, mostly short, some with flagless noise.
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned length;
    sent = 0;
    while (sent < 60) begin
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      for (int unsigned k = 0; k < length; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          sent++;
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      if (length == 0 || $urandom_range(0, 1)) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
      sent += length + 1;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    valid_i          = 1'b0;
    data_byte_i      = '0;
    byte_present_i   = 1'b0;
    end_of_message_i = 1'b0;
    restart_hash();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_messages();
    test_pad_boundaries();
    test_drained_sender();
    test_random_messages();
    wait_for_digests();
    repeat (400) @(posedge clk_i);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("sha256_stream_hasher_test OK");
    end else begin
      $display("sha256_stream_hasher_test NOT OK");
    end
    $finish;
  end

endmodule

/* sha256_stream_hasher.f */
design/sha_pkg.sv
design/sha_round.sv
design/sha256_stream_hasher.sv
bench/sha256_stream_hasher_test.sv
